>>> sv/itoa_pkg.sv
// shared types, constants and helpers for the integer-to-text converter
`default_nettype none

package itoa_pkg;

    // field widths
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;
    localparam int IN_VALUE_W = 64;

    // digit store geometry
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = 6;

    // radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A_LOW = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

    // status from the serial divider to the sequencer
    typedef struct packed {
        logic               done;     // last quotient bit produced this cycle
        logic               nonzero;  // new quotient is not zero
        logic [DIGIT_W-1:0] digit;    // remainder of the finished division
    } div_status_t;

    // digit value to ascii character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE) begin
            c = ASCII_A_LOW + {2'b00, d - DIGIT_TEN};
        end else begin
            c = ASCII_ZERO + {2'b00, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/itoa_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/itoa_div_serial.sv
// bit-serial restoring divider: one quotient bit per cycle while step is high, quotient kept in place
`default_nettype none

module itoa_div_serial #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire logic [VALUE_BITS-1:0]           dividend,
    input  wire logic [itoa_pkg::RADIX_W-1:0]    radix,
    input  wire logic                            step,
    output itoa_pkg::div_status_t                status
);
    import itoa_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]    r_reg, r_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  sticky_reg, sticky_next;

    logic [DIGIT_W:0]   trial;
    logic               ge;
    logic [DIGIT_W:0]   diff;
    logic [DIGIT_W-1:0] r_step;
    logic               last_bit;

    // one step of long division: bring down the next dividend bit
    always_comb begin
        trial    = {r_reg, q_reg[VALUE_BITS-1]};
        ge       = trial >= {1'b0, radix};
        diff     = trial - {1'b0, radix};
        r_step   = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        last_bit = cnt_reg == CNT_LAST;
    end

    // next state of the quotient shift register and partial remainder
    always_comb begin
        q_next      = q_reg;
        r_next      = r_reg;
        cnt_next    = cnt_reg;
        sticky_next = sticky_reg;
        if (load) begin
            q_next      = dividend;
            r_next      = '0;
            cnt_next    = '0;
            sticky_next = 1'b0;
        end else if (step) begin
            q_next = {q_reg[VALUE_BITS-2:0], ge};
            if (last_bit) begin
                r_next      = '0;
                cnt_next    = '0;
                sticky_next = 1'b0;
            end else begin
                r_next      = r_step;
                cnt_next    = cnt_reg + 1'b1;
                sticky_next = sticky_reg | ge;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            sticky_reg <= 1'b0;
            r_reg      <= '0;
            q_reg      <= '0;
        end else begin
            cnt_reg    <= cnt_next;
            sticky_reg <= sticky_next;
            r_reg      <= r_next;
            q_reg      <= q_next;
        end
    end

    // status of the division that finishes this cycle
    always_comb begin
        status.done    = step && last_bit;
        status.nonzero = sticky_reg | ge;
        status.digit   = r_step;
    end

endmodule

`default_nettype wire

>>> sv/integer_to_radix_text.sv
// top level: signed integer to ascii text in radix 2 to 36
//
// Takes one value and radix per input transaction and emits the text one
// character per output transaction, most significant first, with tlast on the
// final character. Digits are made by a bit-serial divider; each digit goes to
// a 64-entry digit store that is then read back in reverse. One item is
// converted at a time; the next is accepted once the last character sits in
// the output register. A radix outside 2 to 36 is clamped, a negative value
// gets a '-' only in radix 10 and is otherwise written as its two's-complement
// pattern of VALUE_BITS bits.
`default_nettype none

module integer_to_radix_text #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input transaction
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [63:0] value, [69:64] radix, rest zero
    // result transaction
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] character
    output logic             m_tlast
);
    import itoa_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MINUS = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_DAT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    logic                minus_reg, minus_next;
    logic [STORE_AW-1:0] ptr_reg, ptr_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0] pattern;
    logic [VALUE_BITS-1:0] magnitude;
    logic [RADIX_W-1:0]    radix_in;
    logic [RADIX_W-1:0]    radix_sat;
    logic                  negative;
    logic                  take_in;
    logic                  out_free;
    logic                  div_load;
    logic [VALUE_BITS-1:0] div_dividend;
    div_status_t           div_status;
    logic                  ram_we;
    logic                  ram_re;
    logic [DIGIT_W-1:0]    ram_rdata;

    // input decode: clamp radix, sign handling for radix ten
    always_comb begin
        pattern   = s_tdata[VALUE_BITS-1:0];
        magnitude = ~pattern + 1'b1;
        radix_in  = s_tdata[IN_VALUE_W +: RADIX_W];
        if (radix_in < RADIX_MIN) begin
            radix_sat = RADIX_MIN;
        end else if (radix_in > RADIX_MAX) begin
            radix_sat = RADIX_MAX;
        end else begin
            radix_sat = radix_in;
        end
        negative     = pattern[VALUE_BITS-1] && (radix_sat == RADIX_DEC);
        div_dividend = negative ? magnitude : pattern;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign take_in  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign div_load = take_in;
    assign ram_we   = div_status.done;
    assign ram_re   = state_reg == ST_RD;

    itoa_div_serial #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (div_load),
        .dividend(div_dividend),
        .radix   (radix_reg),
        .step    (state_reg == ST_DIV),
        .status  (div_status)
    );

    itoa_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ptr_reg),
        .wdata(div_status.digit),
        .re   (ram_re),
        .raddr(ptr_reg),
        .rdata(ram_rdata)
    );

    // sequencer: divide into the store, then read it back in reverse
    always_comb begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        minus_next     = minus_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_in) begin
                    radix_next = radix_sat;
                    minus_next = negative;
                    ptr_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    if (div_status.nonzero) begin
                        ptr_next = ptr_reg + 1'b1;
                    end else begin
                        state_next = minus_reg ? ST_MINUS : ST_RD;
                    end
                end
            end
            ST_MINUS: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASCII_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_DAT;
            end
            ST_DAT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(ram_rdata);
                    out_last_next  = ptr_reg == '0;
                    if (ptr_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            minus_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ptr_reg       <= ptr_next;
            minus_reg     <= minus_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        radix_reg    <= radix_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
